// ===== sv/window_fault_monitor_assert.svh =====
// Assertion macros for the window fault monitor.
// Used by window_fault_monitor.sv; expects a clock clk and an active-low reset rst_n.
`ifndef WINDOW_FAULT_MONITOR_ASSERT_SVH
`define WINDOW_FAULT_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window_fault_monitor check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window_fault_monitor check failed");

`endif

// ===== sv/wfm_pkg.sv =====
// Package for the window fault monitor: payload structs, status codes,
// register indexes and reset values. No dependencies.
`default_nettype none

package wfm_pkg;

    // Status reported with every result.
    typedef enum logic [1:0] {
        ST_NORMAL     = 2'd0,
        ST_WARNING    = 2'd1,
        ST_FAULT      = 2'd2,
        ST_RECOVERING = 2'd3
    } status_t;

    // Item kinds.
    localparam logic KIND_EVAL  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_TRIP    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_TRIP = 2'd3;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned COUNT_W  = 16;

    // Register reset values.
    localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RST  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RST = 16'sh7FFF;
    localparam logic [COUNT_W-1:0]         TRIP_RST       = 16'd1;
    localparam logic [COUNT_W-1:0]         COUNT_MAX      = 16'hFFFF;

    // One input transaction.
    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
    } wfm_in_t;

    // One result transaction.
    typedef struct packed {
        status_t status;
        logic    fault_entered;
    } wfm_out_t;

endpackage

`default_nettype wire

// ===== sv/window_fault_monitor.sv =====
// Window fault monitor top level: window compare with debounce counters.
// Depends on wfm_pkg and window_fault_monitor_assert.svh.
//
// Accepts one transaction per clock and returns exactly one result for each:
// the item is captured in an input register, the window compare and counter
// update run in one combinational pass, and the result lands in an output
// register. With no stall on the result side the throughput is one item every
// cycle; the input side stalls only when both registers are full and the
// result is held.
// Configuration writes take effect on the next cycle and should be made while
// no transaction is in flight.
`default_nettype none

module window_fault_monitor
    import wfm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input channel
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire wfm_in_t                sample_data,
    // Result channel
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output wfm_out_t                    result_data,
    // Configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]     cfg_data
);

    // Configuration registers
    logic signed [SAMPLE_W-1:0] low_limit_reg;
    logic signed [SAMPLE_W-1:0] high_limit_reg;
    logic [COUNT_W-1:0]         fault_trip_reg;
    logic [COUNT_W-1:0]         recovery_trip_reg;

    // Monitor state
    logic               in_fault_reg, in_fault_next;
    logic [COUNT_W-1:0] violation_count_reg, violation_count_next;
    logic [COUNT_W-1:0] recovery_progress_reg, recovery_progress_next;

    // Pipeline registers
    logic     s1_valid_reg, s1_valid_next;
    wfm_in_t  s1_data_reg;
    logic     out_valid_reg, out_valid_next;
    wfm_out_t out_data_reg, out_data_next;

    // Handshake
    logic accept;
    logic out_load;

    // Compare and counter values
    logic               outside;
    logic               in_window;
    logic [COUNT_W-1:0] violation_inc;
    logic [COUNT_W-1:0] recovery_inc;

    // Result register loads from a full input register when empty or when its transaction is taken.
    assign out_load     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !out_load;
    assign accept       = sample_valid && !sample_stall;

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg     <= LOW_LIMIT_RST;
            high_limit_reg    <= HIGH_LIMIT_RST;
            fault_trip_reg    <= TRIP_RST;
            recovery_trip_reg <= TRIP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOW_LIMIT:     low_limit_reg     <= $signed(cfg_data);
                CFG_HIGH_LIMIT:    high_limit_reg    <= $signed(cfg_data);
                CFG_FAULT_TRIP:    fault_trip_reg    <= cfg_data;
                CFG_RECOVERY_TRIP: recovery_trip_reg <= cfg_data;
            endcase
        end
    end

    // Window compares and saturating counter increments.
    always_comb
    begin
        outside = (s1_data_reg.sample < low_limit_reg) || (s1_data_reg.sample > high_limit_reg);
        in_window = (low_limit_reg < s1_data_reg.sample) && (s1_data_reg.sample < high_limit_reg);
        violation_inc = (violation_count_reg == COUNT_MAX) ? COUNT_MAX
                                                           : violation_count_reg + 16'd1;
        recovery_inc  = (recovery_progress_reg == COUNT_MAX) ? COUNT_MAX
                                                             : recovery_progress_reg + 16'd1;
    end

    // State update and result for the item in the input register.
    always_comb
    begin
        in_fault_next          = in_fault_reg;
        violation_count_next   = violation_count_reg;
        recovery_progress_next = recovery_progress_reg;
        out_data_next.status        = ST_NORMAL;
        out_data_next.fault_entered = 1'b0;

        if (s1_data_reg.kind == KIND_CLEAR)
        begin
            in_fault_next          = 1'b0;
            violation_count_next   = '0;
            recovery_progress_next = '0;
        end
        else if (in_fault_reg)
        begin
            if (in_window)
            begin
                if (recovery_inc >= recovery_trip_reg)
                begin
                    in_fault_next          = 1'b0;
                    recovery_progress_next = '0;
                end
                else
                begin
                    recovery_progress_next = recovery_inc;
                    out_data_next.status   = ST_RECOVERING;
                end
            end
            else
            begin
                recovery_progress_next = '0;
                out_data_next.status   = ST_FAULT;
            end
        end
        else
        begin
            if (outside)
            begin
                if (violation_inc >= fault_trip_reg)
                begin
                    in_fault_next               = 1'b1;
                    violation_count_next        = '0;
                    recovery_progress_next      = '0;
                    out_data_next.status        = ST_FAULT;
                    out_data_next.fault_entered = 1'b1;
                end
                else
                begin
                    violation_count_next = violation_inc;
                    out_data_next.status = ST_WARNING;
                end
            end
            else
            begin
                violation_count_next = '0;
            end
        end
    end

    // Pipeline valid bits.
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            in_fault_reg          <= 1'b0;
            violation_count_reg   <= '0;
            recovery_progress_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                in_fault_reg          <= in_fault_next;
                violation_count_reg   <= violation_count_next;
                recovery_progress_reg <= recovery_progress_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= sample_data;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks on the monitor state and results.
`include "window_fault_monitor_assert.svh"

    `WFM_ASSERT_NOW(a_entered_is_fault, result_valid && result_data.fault_entered,
        result_data.status == ST_FAULT)
    `WFM_ASSERT_NOW(a_fault_no_violations, in_fault_reg, violation_count_reg == '0)
    `WFM_ASSERT_NOW(a_normal_no_recovery, !in_fault_reg, recovery_progress_reg == '0)
    `WFM_ASSERT_NEXT(a_entry_sets_fault, out_load && out_data_next.fault_entered,
        in_fault_reg)
    `WFM_ASSERT_NEXT(a_held_item_kept, s1_valid_reg && out_valid_reg && result_stall,
        s1_valid_reg && out_valid_reg)

endmodule

`default_nettype wire
